>>> src/u8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
package u8d_pkg;

    localparam int unsigned CP_W     = 21;
    localparam int unsigned QDEPTH   = 4;
    localparam int unsigned QPTR_W   = $clog2(QDEPTH);
    localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        ST_CP     = 3'd0,
        ST_END    = 3'd1,
        ST_BAD    = 3'd2,
        ST_NULSEQ = 3'd3,
        ST_SURR   = 3'd4,
        ST_LARGE  = 3'd5,
        ST_NONCH  = 3'd6
    } t_status;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        t_status         status;
    } t_result;

endpackage

>>> src/utf8_stream_decoder_core.sv
// Top level of the UTF-8 stream decoder.
//
// Input channel (i_valid/o_ready): one UTF-8 byte per item, with i_last_byte
// marking the final byte of input and i_final_slot saying the consumer has
// room for exactly one more code point.
// Output channel (o_valid/i_ready): zero or one result per byte: a 21-bit
// code point and a 3-bit status (0 code point, 1 end of string, 2 invalid
// or incomplete, 3 NUL inside a sequence, 4 surrogate, 5 above U+10FFFF,
// 6 noncharacter). Error results carry a code point of zero.
// Path: an accepted byte's result enters the queue as the byte is taken, then
// moves into the output register. Throughput: one byte per cycle while the
// queue is not full; each byte is decoded against the pending sequence in a
// combinational front-end step; a 4-entry queue feeds the output register.
// Stalls: when i_ready is low, results collect in the queue; o_ready drops
// only once the queue is full, so short receiver stalls cost no input cycles.
// Reset: synchronous, active low; clears the pending sequence, empties the
// queue and the output register. The block is ready the cycle after reset.
module utf8_stream_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_last_byte,
    input  logic        i_final_slot,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [u8d_pkg::CP_W-1:0] o_code_point,
    output logic [2:0]  o_status
);
    import u8d_pkg::*;

    logic    push, pop, q_full, q_empty;
    t_result push_data, q_head;

    u8d_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_in_byte    (i_in_byte),
        .i_last_byte  (i_last_byte),
        .i_final_slot (i_final_slot),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_push_data  (push_data)
    );

    u8d_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (q_head),
        .o_empty     (q_empty),
        .o_full      (q_full)
    );

    u8d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_head     (q_head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_code_point (o_code_point),
        .o_status     (o_status)
    );

endmodule

>>> src/u8d_front.sv
// Front end: accepts bytes, tracks the pending sequence, classifies results.
module u8d_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_in_byte,
    input  logic              i_last_byte,
    input  logic              i_final_slot,
    input  logic              i_q_full,
    output logic              o_push,
    output u8d_pkg::t_result  o_push_data
);
    import u8d_pkg::*;

    logic [7:0]  r_lead, r_second, r_third;
    logic [1:0]  r_count;
    logic [7:0]  n_lead, n_second, n_third;
    logic [1:0]  n_count;

    logic        accept;
    logic        emit;
    t_result     res;
    logic        nc_ok;
    logic [10:0] cp2;
    logic [15:0] cp3;
    logic [20:0] cp4;

    // no input is taken while reset is held
    assign o_ready = i_rst_n & ~i_q_full;
    assign accept  = i_valid & o_ready;
    assign nc_ok   = i_last_byte & i_final_slot;

    assign cp2 = {r_lead[4:0], i_in_byte[5:0]};
    assign cp3 = {r_lead[3:0], r_second[5:0], i_in_byte[5:0]};
    assign cp4 = {r_lead[2:0], r_second[5:0], r_third[5:0], i_in_byte[5:0]};

    always_comb begin
        n_lead   = r_lead;
        n_second = r_second;
        n_third  = r_third;
        n_count  = r_count;
        emit     = 1'b0;
        res.code_point = '0;
        res.status     = ST_BAD;

        if (!i_in_byte[7]) begin
            emit = 1'b1;
            if (r_count != 2'd0) begin
                res.status = (i_in_byte == 8'h00) ? ST_NULSEQ : ST_BAD;
            end else if (i_in_byte == 8'h00) begin
                res.status = ST_END;
            end else begin
                res.status     = ST_CP;
                res.code_point = {13'd0, i_in_byte};
            end
        end else if (r_count == 2'd0) begin
            n_lead  = i_in_byte;
            n_count = 2'd1;
            emit    = i_last_byte;
        end else if (i_in_byte[7:6] != 2'b10) begin
            emit = 1'b1;
        end else if (r_count == 2'd1) begin
            if (r_lead[7:5] == 3'b110) begin
                emit = 1'b1;
                if (cp2 >= 11'h080) begin
                    res.status     = ST_CP;
                    res.code_point = {10'd0, cp2};
                end
            end else begin
                n_second = i_in_byte;
                n_count  = 2'd2;
                emit     = i_last_byte;
            end
        end else if (r_count == 2'd2) begin
            if (r_lead[7:4] == 4'b1110) begin
                emit = 1'b1;
                if (cp3 < 16'h0800) begin
                    res.status = ST_BAD;
                end else if (cp3[15:11] == 5'b11011) begin
                    res.status = ST_SURR;
                end else if (cp3 >= 16'hFFFE && !nc_ok) begin
                    res.status = ST_NONCH;
                end else begin
                    res.status     = ST_CP;
                    res.code_point = {5'd0, cp3};
                end
            end else begin
                n_third = i_in_byte;
                n_count = 2'd3;
                emit    = i_last_byte;
            end
        end else begin
            emit = 1'b1;
            if (r_lead[7:3] != 5'b11110) begin
                res.status = ST_BAD;
            end else if (cp4[20:16] == 5'd0) begin
                res.status = ST_BAD;
            end else if (cp4[20] && (cp4[19:16] != 4'd0)) begin
                res.status = ST_LARGE;
            end else if (cp4[15:0] >= 16'hFFFE && !nc_ok) begin
                res.status = ST_NONCH;
            end else begin
                res.status     = ST_CP;
                res.code_point = cp4;
            end
        end

        // any result ends the pending sequence
        if (emit) begin
            n_count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (accept) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lead   <= n_lead;
            r_second <= n_second;
            r_third  <= n_third;
        end
    end

    assign o_push      = accept & emit;
    assign o_push_data = res;

endmodule

>>> src/u8d_queue.sv
// Short result queue between the front end and the output stage.
module u8d_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  u8d_pkg::t_result  i_push_data,
    input  logic              i_pop,
    output u8d_pkg::t_result  o_head,
    output logic              o_empty,
    output logic              o_full
);
    import u8d_pkg::*;

    t_result            r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push, do_pop;

    assign o_empty = (r_count == QCNT_W'(0));
    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

>>> src/u8d_back.sv
// Output stage: moves queued results into the output register.
module u8d_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  u8d_pkg::t_result  i_q_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [u8d_pkg::CP_W-1:0] o_code_point,
    output logic [2:0]        o_status
);
    import u8d_pkg::*;

    logic    r_valid;
    t_result r_out;

    // load when the register is empty or is being drained this cycle
    assign o_pop = ~i_q_empty & (~r_valid | i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= i_q_head;
        end
    end

    assign o_valid      = r_valid;
    assign o_code_point = r_out.code_point;
    assign o_status     = r_out.status;

endmodule
